[rtl/rokv_pkg.sv]
`timescale 1ns / 1ps
package rokv_pkg;

   localparam int KEY_WIDTH     = 32;
   localparam int VALUE_WIDTH   = 32;
   localparam int DEFAULT_DEPTH = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic {
      SM_IDLE = 1'b0,
      SM_EXEC = 1'b1
   } state_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic capture;    // latch the compare result against the incoming key
      logic do_insert;  // every cell takes its left neighbour
      logic do_delete;  // cells at or past the first hit take their right neighbour
   } cell_ctrl_type;

endpackage

[rtl/rokv_cell.sv]
`timescale 1ns / 1ps
module rokv_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  rokv_pkg::cell_ctrl_type             ctrl,
   input  logic [rokv_pkg::KEY_WIDTH-1:0]      cmp_key,
   input  logic [rokv_pkg::KEY_WIDTH-1:0]      left_key,
   input  logic [rokv_pkg::VALUE_WIDTH-1:0]    left_value,
   input  logic                                left_valid,
   input  logic [rokv_pkg::KEY_WIDTH-1:0]      right_key,
   input  logic [rokv_pkg::VALUE_WIDTH-1:0]    right_value,
   input  logic                                right_valid,
   input  logic                                hit_prior,
   input  logic [rokv_pkg::VALUE_WIDTH-1:0]    acc_prior,
   output logic                                hit_next,
   output logic [rokv_pkg::VALUE_WIDTH-1:0]    acc_next,
   output logic [rokv_pkg::KEY_WIDTH-1:0]      key_out,
   output logic [rokv_pkg::VALUE_WIDTH-1:0]    value_out,
   output logic                                valid_out
);
   import rokv_pkg::*;

   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   valid_ff, valid_in;
   logic                   match_ff, match_in;
   logic                   first_hit;

   assign first_hit = match_ff & ~hit_prior;
   assign hit_next  = hit_prior | match_ff;
   assign acc_next  = acc_prior | (first_hit ? value_ff : '0);

   assign match_in = ctrl.capture ? (valid_ff && key_ff == cmp_key) : match_ff;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      priority if (ctrl.do_insert) begin
         key_in   = left_key;
         value_in = left_value;
         valid_in = left_valid;
      end else if (ctrl.do_delete && hit_next) begin
         key_in   = right_key;
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;
   assign valid_out = valid_ff;

endmodule

[rtl/recency_ordered_key_value_table_top.sv]
`timescale 1ns / 1ps
// Recency-ordered key/value table built as a row of TABLE_DEPTH cells, newest in cell 0.
// Input channel req_*: tuser carries the operation (insert, search, delete), tdata the
// key in bits 31:0 and the value in bits 63:32. Every request gives one response on rsp_*:
// tuser is the status (ok, not found, full) and tdata the value found, zero otherwise.
// Insert pushes every entry one cell back and writes the new pair in front; an insert
// into a full table is refused. Search returns the newest matching entry; delete also
// removes it and the cells behind close up.
// The key is compared in every cell on the accept edge, and the following
// cycle resolves the first hit along the row and shifts the cells. The response is
// registered at the end of that cycle. No new request is taken while the request
// executes or while a response waits unsent. The first-hit resolution runs through
// the cell row and sets the cycle time for large depths.
// Reset (synchronous, active high) empties the table at once: no clearing pass.
// While rsp_tready is low the response waits in its register; a further request is
// not taken until that response has been transferred or leaves on the same edge.
module recency_ordered_key_value_table_top #(
   parameter int TABLE_DEPTH = rokv_pkg::DEFAULT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] req_key, [63:32] req_value
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] found_value
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import rokv_pkg::*;

   state_type              state_ff, state_in;
   op_type                 op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   cell_ctrl_type          ctrl;
   logic                   req_xfer;
   logic                   rsp_free;
   logic                   table_full;

   logic [KEY_WIDTH-1:0]   cell_key   [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] cell_value [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_valid;
   logic [TABLE_DEPTH:0]   hit_chain;
   logic [VALUE_WIDTH-1:0] acc_chain  [TABLE_DEPTH+1];

   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign req_xfer   = req_tvalid & req_tready;
   assign table_full = cell_valid[TABLE_DEPTH-1];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SM_IDLE: if (req_tvalid && rsp_free) state_in = SM_EXEC;
         SM_EXEC: state_in = SM_IDLE;
         default: state_in = SM_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready     = 1'b0;
      ctrl           = '0;
      unique case (state_ff)
         SM_IDLE: begin
            req_tready   = rsp_free;
            ctrl.capture = req_tvalid & rsp_free;
         end
         SM_EXEC: begin
            ctrl.do_insert = (op_ff == OP_INSERT) && !table_full;
            ctrl.do_delete = (op_ff == OP_DELETE);
         end
         default: ;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (state_ff == SM_EXEC) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = '0;
         unique case (op_ff)
            OP_INSERT: rsp_status_in = table_full ? ST_FULL : ST_OK;
            OP_SEARCH, OP_DELETE: begin
               rsp_status_in = hit_chain[TABLE_DEPTH] ? ST_OK : ST_MISS;
               rsp_value_in  = acc_chain[TABLE_DEPTH];
            end
            default: rsp_status_in = ST_MISS;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      if (req_xfer) begin
         op_ff    <= op_type'(req_tuser);
         key_ff   <= req_tdata[KEY_WIDTH-1:0];
         value_ff <= req_tdata[KEY_WIDTH +: VALUE_WIDTH];
      end
   end

   assign hit_chain[0] = 1'b0;
   assign acc_chain[0] = '0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [KEY_WIDTH-1:0]   l_key, r_key;
      logic [VALUE_WIDTH-1:0] l_value, r_value;
      logic                   l_valid, r_valid;

      if (i == 0) begin : g_head
         assign l_key   = key_ff;
         assign l_value = value_ff;
         assign l_valid = 1'b1;
      end else begin : g_body
         assign l_key   = cell_key[i-1];
         assign l_value = cell_value[i-1];
         assign l_valid = cell_valid[i-1];
      end

      if (i == TABLE_DEPTH-1) begin : g_tail
         // the oldest cell empties when the row closes up on delete
         assign r_key   = cell_key[i];
         assign r_value = cell_value[i];
         assign r_valid = 1'b0;
      end else begin : g_mid
         assign r_key   = cell_key[i+1];
         assign r_value = cell_value[i+1];
         assign r_valid = cell_valid[i+1];
      end

      rokv_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cmp_key     (req_tdata[KEY_WIDTH-1:0]),
         .left_key    (l_key),
         .left_value  (l_value),
         .left_valid  (l_valid),
         .right_key   (r_key),
         .right_value (r_value),
         .right_valid (r_valid),
         .hit_prior   (hit_chain[i]),
         .acc_prior   (acc_chain[i]),
         .hit_next    (hit_chain[i+1]),
         .acc_next    (acc_chain[i+1]),
         .key_out     (cell_key[i]),
         .value_out   (cell_value[i]),
         .valid_out   (cell_valid[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_value_ff;

`ifndef ASSERT_OFF
   // occupied cells always form a prefix of the row
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid + 1'b1) & cell_valid) == '0)
      else $error("occupied cells do not form a prefix");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == SM_EXEC)
      else $error("accepted request did not start execution");

   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == SM_EXEC |=> rsp_valid_ff && state_ff == SM_IDLE)
      else $error("execution did not produce a response");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == SM_EXEC && op_ff == OP_INSERT && table_full |=> $stable(cell_valid))
      else $error("refused insert changed the table");

   a_search_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == SM_EXEC && op_ff == OP_SEARCH |=> $stable(cell_valid))
      else $error("search changed occupancy");
`endif

endmodule

[dv/rokv_table_checker.sv]
`timescale 1ns / 1ps
module rokv_table_checker #(
   parameter int TABLE_DEPTH = rokv_pkg::DEFAULT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] req_key, [63:32] req_value
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] found_value
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   output int          mismatch_count,
   output int          pending_count
);
   import rokv_pkg::*;

   typedef struct packed {
      status_type              status;
      logic [VALUE_WIDTH-1:0]  value;
   } table_reply_type;

   // shadow table, newest entry in slot 0, occupied slots form a prefix
   logic [KEY_WIDTH-1:0]   stored_key   [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] stored_value [TABLE_DEPTH];
   int                     fill_level;
   table_reply_type        pending_replies [$];
   int                     errors;

   task automatic predict_reply(input logic [1:0] mode, input logic [KEY_WIDTH-1:0] key,
                                input logic [VALUE_WIDTH-1:0] value,
                                output table_reply_type reply);
      int hit;
      reply.status = ST_MISS;
      reply.value  = '0;
      hit          = -1;
      case (mode)
         OP_INSERT: begin
            if (fill_level >= TABLE_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               for (int i = fill_level; i > 0; i--) begin
                  stored_key[i]   = stored_key[i-1];
                  stored_value[i] = stored_value[i-1];
               end
               stored_key[0]   = key;
               stored_value[0] = value;
               fill_level++;
               reply.status = ST_OK;
            end
         end
         OP_SEARCH, OP_DELETE: begin
            for (int i = 0; i < fill_level; i++)
               if (hit < 0 && stored_key[i] == key) hit = i;
            if (hit >= 0) begin
               reply.status = ST_OK;
               reply.value  = stored_value[hit];
               if (mode == OP_DELETE) begin
                  for (int i = hit; i + 1 < fill_level; i++) begin
                     stored_key[i]   = stored_key[i+1];
                     stored_value[i] = stored_value[i+1];
                  end
                  fill_level--;
               end
            end
         end
         default: ;  // unused code: no-op, reported as not found
      endcase
   endtask

   always @(posedge clock) begin : monitor
      table_reply_type want;
      if (reset) begin
         fill_level = 0;
         pending_replies.delete();
      end else begin
         // response side first: the transfer on this edge is always an older one
         if (rsp_tvalid && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response with nothing outstanding: status %0d value %h",
                           $time, rsp_tuser, rsp_tdata);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata !== want.value) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: expected status %0d value %h, got status %0d value %h",
                              $time, want.status, want.value, rsp_tuser, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_reply(req_tuser, req_tdata[31:0], req_tdata[63:32], want);
            pending_replies.push_back(want);
         end
      end
      mismatch_count <= errors;
      pending_count  <= pending_replies.size();
   end

endmodule

[dv/recency_ordered_key_value_table_top_tb.sv]
`timescale 1ns / 1ps
module recency_ordered_key_value_table_top_tb;
   import rokv_pkg::*;

   localparam int         TABLE_DEPTH    = DEFAULT_DEPTH;
   localparam int         RANDOM_ITEMS   = 1725;
   localparam int         WATCHDOG_LIMIT = 5000;
   localparam int         HOLD_OFF_START = 1500;
   localparam int         HOLD_OFF_LEN   = 400;
   localparam logic [1:0] OP_UNUSED      = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [31:0] req_key, [63:32] req_value
   logic [1:0]  req_tuser;   // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] found_value
   logic [1:0]  rsp_tuser;   // [1:0] status

   int          mismatch_count;
   int          pending_count;
   int          idle_cycles;
   int          burst_left;
   logic [31:0] key_pool [8];

   recency_ordered_key_value_table_top #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rokv_table_checker #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // one request transfer; gaps fall only between bursts
   task automatic push_request(input logic [1:0] mode, input logic [31:0] key,
                               input logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {value, key};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
   endtask

   // mostly keys from a small pool so that searches and deletes hit
   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return key_pool[$urandom_range(0, 7)];
   endfunction

   // receiver: stretches of differing readiness, plus one long hold-off
   initial begin : receiver
      int cyc;
      int seg_len;
      int ready_pct;
      bit held;
      cyc  = 0;
      held = 1'b0;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && cyc >= HOLD_OFF_START) begin
            held = 1'b1;
            for (int i = 0; i < HOLD_OFF_LEN; i++) begin
               @(posedge clock);
               cyc++;
               rsp_tready <= 1'b0;
            end
         end
         seg_len = $urandom_range(10, 80);
         case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 50;
            2:       ready_pct = 20;
            default: ready_pct = 90;
         endcase
         for (int i = 0; i < seg_len; i++) begin
            @(posedge clock);
            cyc++;
            rsp_tready <= ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** recency_ordered_key_value_table_top: FAILED **");
         $finish;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [1:0] mode;
      int         insert_weight;
      int         roll;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_INSERT;
      burst_left  = 0;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table, unused code, extreme keys and values, duplicate key
      push_request(OP_SEARCH, 32'h0000_0000, 32'h1234_5678);
      push_request(OP_DELETE, 32'hffff_ffff, 32'h0000_0000);
      push_request(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
      push_request(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
      push_request(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
      push_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
      push_request(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff);
      push_request(OP_INSERT, 32'h0000_0000, 32'h0000_0001);
      push_request(OP_SEARCH, 32'h0000_0000, 32'hffff_ffff);
      push_request(OP_DELETE, 32'h0000_0000, 32'h0000_0000);
      push_request(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
      push_request(OP_SEARCH, 32'h1234_5678, 32'h0000_0000);
      // fill up, insert into a full table, then delete from the old end
      for (int i = 0; i < TABLE_DEPTH - 4; i++)
         push_request(OP_INSERT, $urandom, $urandom);
      push_request(OP_INSERT, 32'h5555_5555, 32'haaaa_aaaa);
      push_request(OP_DELETE, 32'h7fff_ffff, 32'h0000_0000);
      push_request(OP_DELETE, 32'h8000_0000, 32'h0000_0000);
      push_request(OP_SEARCH, 32'hffff_ffff, 32'h0000_0000);

      // random part: insert bias drifts so the table swings between empty and full
      insert_weight = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_weight = 15;
               1:       insert_weight = 50;
               default: insert_weight = 85;
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < 2)
            mode = OP_UNUSED;
         else if (roll < 2 + (insert_weight * 98) / 100)
            mode = OP_INSERT;
         else
            mode = $urandom_range(0, 1) ? OP_SEARCH : OP_DELETE;
         push_request(mode, pick_key(), $urandom);
      end
      req_tvalid <= 1'b0;

      // let the checker count the last transfer before draining
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("** recency_ordered_key_value_table_top: PASSED **");
      else
         $display("** recency_ordered_key_value_table_top: FAILED **");
      $finish;
   end

endmodule
